[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MSSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mssl_pkg.sv]
// Package with the payload types, fixed widths and control structs of the loss block.
package mssl_pkg;

	localparam int OBS_W  = 16;
	localparam int GRAD_W = 17;
	localparam int MAG_W  = 16;
	localparam int SQ_W   = 32;
	localparam int LOSS_W = 32;
	localparam logic signed [OBS_W-1:0] HALF_Q412 = 16'sd2048;

	typedef struct packed {
		logic signed [OBS_W-1:0] observed;
		logic signed [OBS_W-1:0] reconstructed;
	} in_word_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gradient;
		logic [LOSS_W-1:0]        loss;
		logic                     vector_done;
	} out_word_t;

	typedef struct packed {
		logic idle;
		logic square;
		logic accum;
		logic div_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_fire;
		logic last;
		logic div_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

[rtl/mssl_in_if.sv]
// Input channel interface carrying one observed and reconstructed pair per word.
interface mssl_in_if import mssl_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/mssl_out_if.sv]
// Output channel interface carrying gradient, loss and the end-of-vector flag.
interface mssl_out_if import mssl_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/mssl_ctrl.sv]
// Controller state machine that sequences accept, square, accumulate, divide and output.
module mssl_ctrl import mssl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQR  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (sts.in_fire) state_nx = ST_SQR;
			ST_SQR:  state_nx = ST_ACC;
			ST_ACC:  state_nx = sts.last ? ST_DIV : ST_PUT;
			ST_DIV:  if (sts.div_done) state_nx = ST_PUT;
			ST_PUT:  if (sts.out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd.idle     = (state_q == ST_IDLE);
		cmd.square   = (state_q == ST_SQR);
		cmd.accum    = (state_q == ST_ACC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_PUT) && sts.out_free;
	end
endmodule

[rtl/mssl_dp.sv]
// Datapath: slot masking, squaring, accumulation, serial divider and output register.
`include "assert_macros.svh"
module mssl_dp import mssl_pkg::*; #(
	parameter int SELF_COUNT  = 16,
	parameter int ENEMY_SLOTS = 4,
	parameter int ENEMY_WIDTH = 8,
	parameter int ALLY_SLOTS  = 4,
	parameter int ALLY_WIDTH  = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output ctrl_sts_t  sts,
	mssl_in_if.sink    samples,
	mssl_out_if.source results
);
	localparam int ENEMY_END = SELF_COUNT + ENEMY_SLOTS * ENEMY_WIDTH;
	localparam int VEC_LEN   = ENEMY_END + ALLY_SLOTS * ALLY_WIDTH;
	localparam int POS_W     = $clog2(VEC_LEN + 1);
	localparam int CNT_W     = $clog2(VEC_LEN + 1);
	localparam int MAX_SW    = (ENEMY_WIDTH > ALLY_WIDTH) ? ENEMY_WIDTH : ALLY_WIDTH;
	localparam int SLOT_W    = $clog2(MAX_SW + 1);
	localparam int SUM_W     = SQ_W + CNT_W;
	localparam int DIV_W     = CNT_W + 1;
	localparam int STEP_W    = $clog2(SUM_W + 1);

	// Position and slot tracking.
	logic [POS_W-1:0]  pos_q;
	logic [SLOT_W-1:0] slot_idx_q;
	logic              slot_valid_q;

	// Per-word pipeline registers.
	logic signed [GRAD_W-1:0] grad_s1;
	logic [MAG_W-1:0]         mag_s1;
	logic                     contrib_s1;
	logic                     last_s1;
	logic [SQ_W-1:0]          sq_s2;

	// Accumulators and divider.
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              zero_cnt_q;

	// Output register.
	logic      out_valid_q;
	out_word_t out_q;

	logic                     fire;
	logic signed [OBS_W-1:0]  obs;
	logic signed [GRAD_W-1:0] diff;
	logic signed [GRAD_W-1:0] neg_diff;
	logic                     in_self;
	logic [SLOT_W-1:0]        width_sel;
	logic                     slot_ok;
	logic                     contrib;
	logic [SLOT_W-1:0]        slot_inc;
	logic                     last_now;
	logic [SUM_W-1:0]         sum_nx;
	logic [CNT_W-1:0]         cnt_nx;
	logic [DIV_W+1:0]         trial;
	logic                     borrow;
	logic [LOSS_W-1:0]        loss_word;
	logic                     out_free;

	assign fire     = samples.valid && samples.ready;
	assign obs      = samples.data.observed;
	assign diff     = {samples.data.reconstructed[OBS_W-1], samples.data.reconstructed}
	                - {obs[OBS_W-1], obs};
	assign neg_diff = -diff;
	assign in_self  = pos_q < POS_W'(SELF_COUNT);
	assign width_sel = (pos_q < POS_W'(ENEMY_END)) ? SLOT_W'(ENEMY_WIDTH) : SLOT_W'(ALLY_WIDTH);
	// The first element of each slot decides whether the whole slot counts.
	assign slot_ok  = (slot_idx_q == '0) ? (obs > HALF_Q412) : slot_valid_q;
	assign contrib  = in_self || slot_ok;
	assign slot_inc = slot_idx_q + SLOT_W'(1);
	assign last_now = pos_q >= POS_W'(VEC_LEN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			slot_idx_q   <= '0;
			slot_valid_q <= 1'b0;
		end else if (fire) begin
			if (last_now) begin
				pos_q        <= '0;
				slot_idx_q   <= '0;
				slot_valid_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (!in_self) begin
					slot_valid_q <= slot_ok;
					slot_idx_q   <= (slot_inc >= width_sel) ? '0 : slot_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			grad_s1    <= contrib ? diff : '0;
			mag_s1     <= contrib ? (diff[GRAD_W-1] ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0])
			                      : '0;
			contrib_s1 <= contrib;
			last_s1    <= last_now;
		end
		if (cmd.square) begin
			sq_s2 <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
		end
	end

	assign sum_nx = sum_q + SUM_W'(sq_s2);
	assign cnt_nx = cnt_q + CNT_W'(contrib_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.accum) begin
			if (last_s1) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

	// Restoring divider: one quotient bit per cycle, sum over twice the count.
	assign trial  = {1'b0, rem_q, quo_q[SUM_W-1]} - {2'b00, dvs_q};
	assign borrow = trial[DIV_W+1];

	always_ff @(posedge clk) begin
		if (cmd.accum && last_s1) begin
			quo_q      <= sum_nx;
			rem_q      <= '0;
			dvs_q      <= {cnt_nx, 1'b0};
			zero_cnt_q <= (cnt_nx == '0);
			step_q     <= '0;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[SUM_W-2:0], ~borrow};
			rem_q  <= borrow ? {rem_q[DIV_W-2:0], quo_q[SUM_W-1]} : trial[DIV_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign loss_word = (last_s1 && !zero_cnt_q) ? quo_q[LOSS_W-1:0] : '0;
	assign out_free  = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.gradient    <= grad_s1;
			out_q.loss        <= loss_word;
			out_q.vector_done <= last_s1;
		end
	end

	assign samples.ready = cmd.idle;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	always_comb begin
		sts.in_fire  = fire;
		sts.last     = last_s1;
		sts.div_done = (step_q == STEP_W'(SUM_W - 1));
		sts.out_free = out_free;
	end

	`MSSL_ASSERT(a_load_free, !cmd.load_out || out_free, "output word overwritten before taken")
	`MSSL_ASSERT(a_loss_only_last, !out_valid_q || out_q.vector_done || out_q.loss == '0, "early loss")
	`MSSL_ASSERT_NEXT(a_wrap_pos, fire && last_now, pos_q == '0, "position did not wrap")
endmodule

[rtl/masked_slot_mse_loss.sv]
// Top level of the masked slot mean-squared-error loss block.
//
//  channel   dir  payload                               handshake
//  samples   in   observed, reconstructed (Q4.12)       valid/ready
//  results   out  gradient, loss (Q8.24), vector_done   valid/ready
//
// An ordinary word steps through accept, square, accumulate and output load.
// The last word of a vector also passes through the bit-serial divider, whose dividend
// is SQ_W plus count width bits (39 by default), to form the sum over twice count.
// A new word is accepted while the previous result still waits in the output register.
// A stalled output holds the controller in its output state until the word is taken.
// Reset clears the vector position, slot tracking, accumulators and valid flags.
module masked_slot_mse_loss import mssl_pkg::*; #(
	parameter int SELF_COUNT  = 16,
	parameter int ENEMY_SLOTS = 4,
	parameter int ENEMY_WIDTH = 8,
	parameter int ALLY_SLOTS  = 4,
	parameter int ALLY_WIDTH  = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	mssl_in_if.sink    samples,
	mssl_out_if.source results
);
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	mssl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mssl_dp #(
		.SELF_COUNT  (SELF_COUNT),
		.ENEMY_SLOTS (ENEMY_SLOTS),
		.ENEMY_WIDTH (ENEMY_WIDTH),
		.ALLY_SLOTS  (ALLY_SLOTS),
		.ALLY_WIDTH  (ALLY_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.samples (samples),
		.results (results)
	);
endmodule
